FILE: sv/cmsc_pkg.sv
// cmsc_pkg: shared types, constants and helpers of the cell matrix scan and charge controller
// no dependencies; every other file refers to it by scoped names

package cmsc_pkg;

    // grid geometry, one grid per board
    localparam int GRID_W      = 8;
    localparam int GRID_H      = 8;
    localparam int NUM_BOARDS  = 2;
    localparam int CELLS       = GRID_W * GRID_H;
    localparam int MAP_DEPTH   = NUM_BOARDS * CELLS;
    localparam int MAP_ADDR_W  = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int SCAN_COL_W  = (GRID_W > 1) ? $clog2(GRID_W) : 1;
    localparam int SCAN_ROW_W  = (GRID_H > 1) ? $clog2(GRID_H) : 1;

    localparam int COORD_W     = 3;
    localparam int OP_W        = 3;
    localparam int SAMPLE_W    = 16;
    localparam int TIME_W      = 32;
    localparam int MODE_W      = 2;

    // command codes
    localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
    localparam logic [OP_W-1:0] OP_SCAN     = 3'd1;
    localparam logic [OP_W-1:0] OP_CHARGE   = 3'd2;
    localparam logic [OP_W-1:0] OP_HOLD     = 3'd3;
    localparam logic [OP_W-1:0] OP_END_HOLD = 3'd4;
    localparam logic [OP_W-1:0] OP_READ     = 3'd5;

    // configuration register map
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;
    localparam int REG_IDX_W   = 1;
    localparam logic [REG_IDX_W-1:0] REG_PRESENT_THRESHOLD = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_CHARGE_TIMEOUT    = 1'd1;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 16'd0;
    localparam logic [TIME_W-1:0]   TIMEOUT_RESET   = 32'd1000;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic                board;
        logic [COORD_W-1:0]  cell_x;
        logic [COORD_W-1:0]  cell_y;
        logic [SAMPLE_W-1:0] current_sample;
        logic [TIME_W-1:0]   now_ms;
    } t_in_item;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               level_pop;
        logic               select_first;
        logic               select_second;
        logic [COORD_W-1:0] drive_x;
        logic [COORD_W-1:0] drive_y;
        logic               present;
        logic               charge_ended;
        logic               scan_done;
    } t_out_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] present_threshold;
        logic [TIME_W-1:0]   charge_timeout_ms;
    } t_cfg;

    // write and board-clear requests towards the presence map
    typedef struct packed {
        logic                  wr_en;
        logic [MAP_ADDR_W-1:0] wr_addr;
        logic                  wr_data;
        logic                  clr_en;
        logic                  clr_board;
    } t_map_wr;

    // board-major, then column, row fastest
    function automatic logic [MAP_ADDR_W-1:0] map_addr(input logic b,
                                                       input int unsigned x,
                                                       input int unsigned y);
        int unsigned a;
        a = 32'(b) * CELLS + x * GRID_H + y;
        return a[MAP_ADDR_W-1:0];
    endfunction

endpackage

FILE: sv/cell_matrix_scan_charge_controller_top.sv
// cell_matrix_scan_charge_controller_top: input stage, result register and handshakes
// depends on cmsc_pkg, cmsc_cfg_regs, cmsc_presence_map, cmsc_ctrl
//
//  channel   | signals                                      | payload
//  ----------+----------------------------------------------+------------------------
//  command   | i_in_valid / o_in_ready                      | i_in_data  (t_in_item)
//  result    | o_out_valid / i_out_ready                    | o_out_data (t_out_item)
//  config    | psel penable pwrite paddr pwdata prdata pready | threshold, charge timeout
//
// one word per cycle sustained unless the result stalls; o_out_valid rises after the word
// leaves the input stage (presence map read registered on acceptance, then one pass of
// control logic into the result register). reset is synchronous and clears mode, valid
// flags and the presence map valid bits together, no sweep. a stalled result holds the
// input stage, which holds o_in_ready low until the result register frees.

module cell_matrix_scan_charge_controller_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  cmsc_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output cmsc_pkg::t_out_item             o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cmsc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cmsc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [cmsc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic                 r_s1_valid;
    cmsc_pkg::t_in_item   r_s1_item;
    logic                 r_out_valid;
    cmsc_pkg::t_out_item  r_out;

    logic                 in_acc;
    logic                 commit;
    logic                 map_present;
    cmsc_pkg::t_cfg       cfg;
    cmsc_pkg::t_map_wr    map_wr;
    cmsc_pkg::t_out_item  result;

    assign commit     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || commit;
    assign in_acc     = i_in_valid && o_in_ready;

    cmsc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cmsc_presence_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (cmsc_pkg::map_addr(i_in_data.board, 32'(i_in_data.cell_x),
                                       32'(i_in_data.cell_y))),
        .i_wr      (map_wr),
        .o_present (map_present)
    );

    cmsc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_commit      (commit),
        .i_item        (r_s1_item),
        .i_cfg         (cfg),
        .i_map_present (map_present),
        .o_result      (result),
        .o_map_wr      (map_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (commit) begin
                r_s1_valid <= 1'b0;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item <= i_in_data;
        end
        if (commit) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: sv/cmsc_cfg_regs.sv
// cmsc_cfg_regs: apb-style register file for threshold and charge timeout
// depends on cmsc_pkg

module cmsc_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cmsc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cmsc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [cmsc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output cmsc_pkg::t_cfg                  o_cfg
);

    logic [cmsc_pkg::SAMPLE_W-1:0] r_threshold;
    logic [cmsc_pkg::TIME_W-1:0]   r_timeout;
    logic [cmsc_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_en;

    assign reg_idx = paddr[cmsc_pkg::CFG_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= cmsc_pkg::THRESHOLD_RESET;
            r_timeout   <= cmsc_pkg::TIMEOUT_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                cmsc_pkg::REG_PRESENT_THRESHOLD: begin
                    r_threshold <= pwdata[cmsc_pkg::SAMPLE_W-1:0];
                end
                cmsc_pkg::REG_CHARGE_TIMEOUT: begin
                    r_timeout <= pwdata[cmsc_pkg::TIME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            cmsc_pkg::REG_PRESENT_THRESHOLD: begin
                prdata = {{(cmsc_pkg::CFG_DATA_W-cmsc_pkg::SAMPLE_W){1'b0}}, r_threshold};
            end
            cmsc_pkg::REG_CHARGE_TIMEOUT: begin
                prdata = r_timeout;
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_cfg.present_threshold = r_threshold;
    assign o_cfg.charge_timeout_ms = r_timeout;

endmodule

FILE: sv/cmsc_presence_map.sv
// cmsc_presence_map: presence bits of both boards, registered-read memory plus per-entry valid flops
// depends on cmsc_pkg; clearing a board drops all its valid bits together

module cmsc_presence_map (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rd_en,
    input  logic [cmsc_pkg::MAP_ADDR_W-1:0] i_rd_addr,
    input  cmsc_pkg::t_map_wr               i_wr,
    output logic                            o_present
);

    logic                            r_mem [0:cmsc_pkg::MAP_DEPTH-1];
    logic [cmsc_pkg::MAP_DEPTH-1:0]  r_valid;
    logic                            r_rd_q;
    logic [cmsc_pkg::MAP_ADDR_W-1:0] r_rd_addr;
    logic                            r_fwd;
    logic                            r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_en) begin
            r_mem[i_wr.wr_addr] <= i_wr.wr_data;
        end
        if (i_rd_en) begin
            r_rd_q     <= r_mem[i_rd_addr];
            r_rd_addr  <= i_rd_addr;
            // a write landing on the same edge is not yet in the array
            r_fwd      <= i_wr.wr_en && (i_wr.wr_addr == i_rd_addr);
            r_fwd_data <= i_wr.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int i = 0; i < cmsc_pkg::MAP_DEPTH; i++) begin
                if (i_wr.clr_en && (i >= int'(i_wr.clr_board) * cmsc_pkg::CELLS)
                        && (i < (int'(i_wr.clr_board) + 1) * cmsc_pkg::CELLS)) begin
                    r_valid[i] <= 1'b0;
                end
            end
            if (i_wr.wr_en) begin
                r_valid[i_wr.wr_addr] <= 1'b1;
            end
        end
    end

    // valid flops are current by the time the item is worked on
    assign o_present = r_valid[r_rd_addr] & (r_fwd ? r_fwd_data : r_rd_q);

endmodule

FILE: sv/cmsc_ctrl.sv
// cmsc_ctrl: mode state, scan walk, charge timing and the result of each command word
// depends on cmsc_pkg; fed by the input stage, presence map and config registers

module cmsc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_commit,
    input  cmsc_pkg::t_in_item  i_item,
    input  cmsc_pkg::t_cfg      i_cfg,
    input  logic                i_map_present,
    output cmsc_pkg::t_out_item o_result,
    output cmsc_pkg::t_map_wr   o_map_wr
);

    typedef enum logic [cmsc_pkg::MODE_W-1:0] {
        MODE_IDLE     = 2'd0,
        MODE_CHARGING = 2'd1,
        MODE_SCANNING = 2'd2,
        MODE_HOLDING  = 2'd3
    } t_mode;

    t_mode                             r_mode, n_mode;
    logic                              r_charge_board, n_charge_board;
    logic [cmsc_pkg::COORD_W-1:0]      r_charge_x, n_charge_x;
    logic [cmsc_pkg::COORD_W-1:0]      r_charge_y, n_charge_y;
    logic [cmsc_pkg::TIME_W-1:0]       r_charge_start, n_charge_start;
    logic                              r_scan_board, n_scan_board;
    logic [cmsc_pkg::SCAN_COL_W-1:0]   r_scan_col, n_scan_col;
    logic [cmsc_pkg::SCAN_ROW_W-1:0]   r_scan_row, n_scan_row;
    logic                              r_awaiting, n_awaiting;
    logic                              r_hold_board, n_hold_board;
    logic [1:0]                        r_select, n_select;
    logic                              r_pop, n_pop;
    logic [cmsc_pkg::COORD_W-1:0]      r_drive_x, n_drive_x;
    logic [cmsc_pkg::COORD_W-1:0]      r_drive_y, n_drive_y;

    logic                              present;
    logic                              ended;
    logic                              done;
    logic                              in_grid;
    logic [cmsc_pkg::TIME_W-1:0]       elapsed;

    assign in_grid = (32'(i_item.cell_x) < cmsc_pkg::GRID_W)
                  && (32'(i_item.cell_y) < cmsc_pkg::GRID_H);
    assign elapsed = i_item.now_ms - r_charge_start;

    always_comb begin
        n_mode         = r_mode;
        n_charge_board = r_charge_board;
        n_charge_x     = r_charge_x;
        n_charge_y     = r_charge_y;
        n_charge_start = r_charge_start;
        n_scan_board   = r_scan_board;
        n_scan_col     = r_scan_col;
        n_scan_row     = r_scan_row;
        n_awaiting     = r_awaiting;
        n_hold_board   = r_hold_board;
        n_select       = r_select;
        n_pop          = r_pop;
        n_drive_x      = r_drive_x;
        n_drive_y      = r_drive_y;
        present        = 1'b0;
        ended          = 1'b0;
        done           = 1'b0;
        o_map_wr.wr_en     = 1'b0;
        o_map_wr.wr_addr   = cmsc_pkg::map_addr(r_scan_board, 32'(r_scan_col),
                                                32'(r_scan_row));
        o_map_wr.wr_data   = 1'b0;
        o_map_wr.clr_en    = 1'b0;
        o_map_wr.clr_board = i_item.board;

        case (i_item.op)
            cmsc_pkg::OP_TICK: begin
                case (r_mode)
                    MODE_SCANNING: begin
                        if (!r_awaiting) begin
                            n_drive_x  = cmsc_pkg::COORD_W'(r_scan_col);
                            n_drive_y  = cmsc_pkg::COORD_W'(r_scan_row);
                            n_awaiting = 1'b1;
                        end else begin
                            present          = i_item.current_sample >= i_cfg.present_threshold;
                            o_map_wr.wr_en   = 1'b1;
                            o_map_wr.wr_data = present;
                            n_awaiting       = 1'b0;
                            if (r_scan_row == cmsc_pkg::SCAN_ROW_W'(cmsc_pkg::GRID_H - 1)) begin
                                n_scan_row = '0;
                                if (r_scan_col == cmsc_pkg::SCAN_COL_W'(cmsc_pkg::GRID_W - 1)) begin
                                    n_select[r_scan_board] = 1'b0;
                                    n_pop  = 1'b0;
                                    n_mode = MODE_IDLE;
                                    done   = 1'b1;
                                end else begin
                                    n_scan_col = r_scan_col + 1'b1;
                                end
                            end else begin
                                n_scan_row = r_scan_row + 1'b1;
                            end
                        end
                    end
                    MODE_HOLDING: begin
                    end
                    MODE_IDLE: begin
                        n_select[r_charge_board] = 1'b0;
                        n_pop = 1'b0;
                    end
                    default: begin
                        // charging: drive the target, stop on timeout
                        if (elapsed >= i_cfg.charge_timeout_ms) begin
                            n_select[r_charge_board] = 1'b0;
                            n_pop  = 1'b0;
                            n_mode = MODE_IDLE;
                            ended  = 1'b1;
                        end else begin
                            n_select[r_charge_board] = 1'b1;
                            n_pop  = 1'b1;
                        end
                        n_drive_x = r_charge_x;
                        n_drive_y = r_charge_y;
                    end
                endcase
            end
            cmsc_pkg::OP_SCAN: begin
                if (r_mode == MODE_IDLE) begin
                    n_select[i_item.board] = 1'b1;
                    n_pop           = 1'b0;
                    o_map_wr.clr_en = 1'b1;
                    n_scan_board    = i_item.board;
                    n_scan_col      = '0;
                    n_scan_row      = '0;
                    n_awaiting      = 1'b0;
                    n_mode          = MODE_SCANNING;
                end
            end
            cmsc_pkg::OP_CHARGE: begin
                if (r_mode != MODE_CHARGING) begin
                    n_charge_x     = i_item.cell_x;
                    n_charge_y     = i_item.cell_y;
                    n_charge_board = i_item.board;
                    n_charge_start = i_item.now_ms;
                    n_mode         = MODE_CHARGING;
                end
            end
            cmsc_pkg::OP_HOLD: begin
                if (r_mode == MODE_IDLE) begin
                    n_pop        = 1'b0;
                    n_drive_x    = i_item.cell_x;
                    n_drive_y    = i_item.cell_y;
                    n_select[i_item.board] = 1'b1;
                    n_hold_board = i_item.board;
                    n_mode       = MODE_HOLDING;
                end
            end
            cmsc_pkg::OP_END_HOLD: begin
                if (r_mode == MODE_HOLDING) begin
                    n_select[r_hold_board] = 1'b0;
                    n_pop  = 1'b0;
                    n_mode = MODE_IDLE;
                end
            end
            cmsc_pkg::OP_READ: begin
                present = in_grid & i_map_present;
            end
            default: begin
            end
        endcase

        if (!i_commit) begin
            o_map_wr.wr_en  = 1'b0;
            o_map_wr.clr_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_IDLE;
            r_charge_board <= 1'b0;
            r_charge_x     <= '0;
            r_charge_y     <= '0;
            r_charge_start <= '0;
            r_scan_board   <= 1'b0;
            r_scan_col     <= '0;
            r_scan_row     <= '0;
            r_awaiting     <= 1'b0;
            r_hold_board   <= 1'b0;
            r_select       <= '0;
            r_pop          <= 1'b0;
            r_drive_x      <= '0;
            r_drive_y      <= '0;
        end else if (i_commit) begin
            r_mode         <= n_mode;
            r_charge_board <= n_charge_board;
            r_charge_x     <= n_charge_x;
            r_charge_y     <= n_charge_y;
            r_charge_start <= n_charge_start;
            r_scan_board   <= n_scan_board;
            r_scan_col     <= n_scan_col;
            r_scan_row     <= n_scan_row;
            r_awaiting     <= n_awaiting;
            r_hold_board   <= n_hold_board;
            r_select       <= n_select;
            r_pop          <= n_pop;
            r_drive_x      <= n_drive_x;
            r_drive_y      <= n_drive_y;
        end
    end

    assign o_result.mode          = n_mode;
    assign o_result.level_pop     = n_pop;
    assign o_result.select_first  = n_select[0];
    assign o_result.select_second = n_select[1];
    assign o_result.drive_x       = n_drive_x;
    assign o_result.drive_y       = n_drive_y;
    assign o_result.present       = present;
    assign o_result.charge_ended  = ended;
    assign o_result.scan_done     = done;

endmodule
